[design/bit_packed_rle_decoder_macros.svh]
// Assertion macros for the bit-packed RLE decoder checker.
// Needs nothing else; included by every file that asserts.
`ifndef BIT_PACKED_RLE_DECODER_MACROS_SVH
`define BIT_PACKED_RLE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define BPRLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define BPRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bprle_pkg.sv]
// Shared types and constants of the bit-packed RLE decoder.
// Used by the register block, controller, datapath and top level.
package bprle_pkg;

  localparam int MAX_PIXELS_DEF  = 65536;
  localparam int GROUP_LANES_DEF = 8;

  localparam int BYTE_W   = 8;
  localparam int WIN_W    = 16;
  localparam int FILL_W   = 5;
  localparam int RUN_W    = 8;
  localparam int BITS_W   = 20;
  localparam int GROUP_W  = 64;
  localparam int COUNT_W  = 4;
  localparam int VBITS_W  = 4;
  localparam int TOTAL_W  = 17;
  localparam int LIMIT_W  = 16;
  localparam int RESN_W   = 5;
  localparam int ADDR_W   = 4;
  localparam int PDATA_W  = 32;
  localparam int OUSER_W  = 5;

  // Results from decoded values allowed in one item; one more is kept for the flush
  localparam logic [RESN_W-1:0] RES_BUDGET = 5'd17;

  // Control field codes
  localparam logic [BYTE_W-1:0] CTRL_NOP = 8'd128;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_VALUE_BITS  = 2'd0;
  localparam logic [1:0] REG_PIXEL_TOTAL = 2'd1;
  localparam logic [1:0] REG_BYTE_LIMIT  = 2'd2;

  typedef enum logic [1:0] {
    PH_CTRL,
    PH_RVAL,
    PH_LIT,
    PH_REP
  } phase_t;

  typedef enum logic {
    ST_IDLE,
    ST_DECODE
  } ctl_state_t;

  typedef struct packed {
    logic [VBITS_W-1:0] value_bits;
    logic [TOTAL_W-1:0] pixel_total;
    logic [LIMIT_W-1:0] control_byte_limit;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip;
    logic stop;
    logic step_push;
    logic flush_need;
    logic out_free;
  } dp_stat_t;

endpackage

[design/bprle_regs.sv]
// Configuration registers of the bit-packed RLE decoder behind an APB-style port.
// Depends on bprle_pkg.
module bprle_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bprle_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [bprle_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [bprle_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready,
  output bprle_pkg::cfg_t               cfg
);

  bprle_pkg::cfg_t cfg_r;
  bprle_pkg::cfg_t cfg_nxt;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        bprle_pkg::REG_VALUE_BITS:
          cfg_nxt.value_bits = cfg_pwdata[bprle_pkg::VBITS_W-1:0];
        bprle_pkg::REG_PIXEL_TOTAL:
          cfg_nxt.pixel_total = cfg_pwdata[bprle_pkg::TOTAL_W-1:0];
        bprle_pkg::REG_BYTE_LIMIT:
          cfg_nxt.control_byte_limit = cfg_pwdata[bprle_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      bprle_pkg::REG_VALUE_BITS:
        cfg_prdata = bprle_pkg::PDATA_W'(cfg_r.value_bits);
      bprle_pkg::REG_PIXEL_TOTAL:
        cfg_prdata = bprle_pkg::PDATA_W'(cfg_r.pixel_total);
      bprle_pkg::REG_BYTE_LIMIT:
        cfg_prdata = bprle_pkg::PDATA_W'(cfg_r.control_byte_limit);
      default:
        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.value_bits         <= 4'd8;
      cfg_r.pixel_total        <= 17'd65536;
      cfg_r.control_byte_limit <= 16'd65535;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[design/bprle_ctrl.sv]
// Controller of the bit-packed RLE decoder: takes in bytes and sequences decode steps.
// Depends on bprle_pkg.
module bprle_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  bprle_pkg::dp_stat_t   stat,
  output bprle_pkg::dp_cmd_t    cmd
);

  bprle_pkg::ctl_state_t state_r;
  bprle_pkg::ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bprle_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      bprle_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (!stat.skip) begin
            state_nxt = bprle_pkg::ST_DECODE;
          end
        end
      end
      bprle_pkg::ST_DECODE: begin
        if (!stat.stop) begin
          // hold a step whose result has nowhere to go
          if (!stat.step_push || stat.out_free) begin
            cmd.step = 1'b1;
          end
        end else if (stat.flush_need) begin
          if (stat.out_free) begin
            cmd.flush = 1'b1;
            state_nxt = bprle_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = bprle_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bprle_pkg::ST_IDLE;
    endcase
  end

endmodule

[design/bprle_dpath.sv]
// Datapath of the bit-packed RLE decoder: bit window, run state, group packer, output register.
// Depends on bprle_pkg; driven by bprle_ctrl through dp_cmd_t.
module bprle_dpath #(
  parameter int MAX_PIXELS  = bprle_pkg::MAX_PIXELS_DEF,
  parameter int GROUP_LANES = bprle_pkg::GROUP_LANES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bprle_pkg::cfg_t               cfg,
  input  bprle_pkg::dp_cmd_t            cmd,
  output bprle_pkg::dp_stat_t           stat,
  input  logic [bprle_pkg::BYTE_W-1:0]  in_tdata,
  input  logic [0:0]                    in_tuser,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bprle_pkg::GROUP_W-1:0] out_tdata,
  output logic [bprle_pkg::OUSER_W-1:0] out_tuser,
  output logic                          out_tlast
);

  localparam int VW = $clog2(MAX_PIXELS + 1);
  localparam int TW = (VW > bprle_pkg::TOTAL_W) ? VW : bprle_pkg::TOTAL_W;
  localparam int W  = bprle_pkg::WIN_W;
  localparam int FW = bprle_pkg::FILL_W;
  localparam int BW = bprle_pkg::BYTE_W;
  localparam int RW = bprle_pkg::RUN_W;
  localparam int CW = bprle_pkg::BITS_W;
  localparam int GW = bprle_pkg::GROUP_W;
  localparam int NW = bprle_pkg::COUNT_W;

  // Decoder state
  logic [W-1:0]            win_r, win_nxt;
  logic [FW-1:0]           fill_r, fill_nxt;
  bprle_pkg::phase_t       phase_r, phase_nxt;
  logic [RW-1:0]           run_r, run_nxt;
  logic [BW-1:0]           held_r, held_nxt;
  logic [CW-1:0]           bits_r, bits_nxt;
  logic [VW-1:0]           done_cnt_r, done_cnt_nxt;
  logic [GW-1:0]           grp_r, grp_nxt;
  logic [NW-1:0]           gfill_r, gfill_nxt;
  logic                    img_done_r, img_done_nxt;
  logic                    end_r, end_nxt;
  logic [bprle_pkg::RESN_W-1:0] resn_r, resn_nxt;

  // Output register
  logic                    ovalid_r, ovalid_nxt;
  logic [GW-1:0]           odata_r, odata_nxt;
  logic [NW-1:0]           ocount_r, ocount_nxt;
  logic                    olast_r, olast_nxt;
  logic                    oshort_r, oshort_nxt;

  // Effective configuration
  logic [bprle_pkg::VBITS_W-1:0] vb;
  logic [TW-1:0]           total;
  logic [TW-1:0]           done_ext;
  logic [TW-1:0]           done_inc;

  // Take unit
  logic [bprle_pkg::VBITS_W-1:0] take_n;
  logic [FW-1:0]           take_sh;
  logic [BW-1:0]           take_mask;
  logic [BW-1:0]           take_v;
  logic [W-1:0]            take_rem;
  logic                    fill_ok;
  logic [CW:0]             bits_sum;
  logic [CW-1:0]           bits_sat;
  logic                    limit_hit;

  // Step decision
  logic                    img_over;
  logic                    push_if_emit;
  logic                    can_emit;
  logic                    stop_c, do_take, do_emit, do_held;
  bprle_pkg::phase_t       phase_c;
  logic [RW-1:0]           run_c;
  logic [BW-1:0]           emit_val;
  logic [GW-1:0]           grp_ins;
  logic [NW-1:0]           gfill_inc;
  logic                    emit_final;
  logic                    emit_push;
  logic                    out_free;

  // Base state for a load, after an optional clear
  logic [W-1:0]            base_win;
  logic [FW-1:0]           base_fill;

  // Clamp the configuration
  assign vb = (cfg.value_bits == '0) ? 4'd1 :
              (cfg.value_bits > 4'd8) ? 4'd8 : cfg.value_bits;
  assign total = (TW'(cfg.pixel_total) > TW'(MAX_PIXELS)) ? TW'(MAX_PIXELS)
                                                         : TW'(cfg.pixel_total);
  assign done_ext = TW'(done_cnt_r);
  assign done_inc = done_ext + TW'(1);
  assign img_over = img_done_r || (done_ext >= total);

  // Take n bits from the top of the window, MSB first
  assign take_n    = (phase_r == bprle_pkg::PH_CTRL) ? 4'd8 : vb;
  assign fill_ok   = fill_r >= FW'(take_n);
  assign take_sh   = fill_r - FW'(take_n);
  assign take_mask = BW'((9'd1 << take_n) - 9'd1);
  assign take_v    = BW'(win_r >> take_sh) & take_mask;
  assign take_rem  = win_r & W'((17'd1 << take_sh) - 17'd1);
  assign bits_sum  = {1'b0, bits_r} + (CW + 1)'(take_n);
  assign bits_sat  = bits_sum[CW] ? {CW{1'b1}} : bits_sum[CW-1:0];
  assign limit_hit = bits_r >= CW'({cfg.control_byte_limit, 3'b000});

  // Result budget check for a value that would close a group
  assign push_if_emit = (gfill_r + NW'(1) >= NW'(GROUP_LANES)) || (done_inc >= total);
  assign can_emit     = !push_if_emit || (resn_r < bprle_pkg::RES_BUDGET);

  // Pick one decode step
  always_comb begin
    stop_c  = 1'b0;
    do_take = 1'b0;
    do_emit = 1'b0;
    do_held = 1'b0;
    phase_c = phase_r;
    run_c   = run_r;
    if (img_over) begin
      stop_c = 1'b1;
    end else begin
      case (phase_r)
        bprle_pkg::PH_REP: begin
          if (run_r == '0) begin
            phase_c = bprle_pkg::PH_CTRL;
          end else if (!can_emit) begin
            stop_c = 1'b1;
          end else begin
            do_emit = 1'b1;
            run_c   = run_r - RW'(1);
          end
        end
        bprle_pkg::PH_CTRL: begin
          if (limit_hit || !fill_ok) begin
            stop_c = 1'b1;
          end else begin
            do_take = 1'b1;
            if (take_v > bprle_pkg::CTRL_NOP) begin
              run_c   = RW'(9'd257 - {1'b0, take_v});
              phase_c = bprle_pkg::PH_RVAL;
            end else if (take_v < bprle_pkg::CTRL_NOP) begin
              run_c   = take_v + RW'(1);
              phase_c = bprle_pkg::PH_LIT;
            end
          end
        end
        bprle_pkg::PH_RVAL: begin
          if (!fill_ok) begin
            stop_c = 1'b1;
          end else begin
            do_take = 1'b1;
            do_held = 1'b1;
            phase_c = bprle_pkg::PH_REP;
          end
        end
        bprle_pkg::PH_LIT: begin
          if (run_r == '0) begin
            phase_c = bprle_pkg::PH_CTRL;
          end else if (!fill_ok || !can_emit) begin
            stop_c = 1'b1;
          end else begin
            do_take = 1'b1;
            do_emit = 1'b1;
            run_c   = run_r - RW'(1);
            if (run_r == RW'(1)) begin
              phase_c = bprle_pkg::PH_CTRL;
            end
          end
        end
        default: stop_c = 1'b1;
      endcase
    end
  end

  // Pack the value into its lane
  assign emit_val   = (phase_r == bprle_pkg::PH_REP) ? held_r : take_v;
  assign grp_ins    = grp_r | (GW'(emit_val) << {gfill_r[2:0], 3'b000});
  assign gfill_inc  = gfill_r + NW'(1);
  assign emit_final = done_inc >= total;
  assign emit_push  = do_emit && push_if_emit;

  assign out_free  = !ovalid_r || out_tready;
  assign base_win  = in_tuser[0] ? '0 : win_r;
  assign base_fill = in_tuser[0] ? '0 : fill_r;

  assign stat.skip       = !in_tuser[0] && img_done_r;
  assign stat.stop       = stop_c;
  assign stat.step_push  = emit_push;
  assign stat.flush_need = end_r && !img_done_r;
  assign stat.out_free   = out_free;

  // Next state
  always_comb begin
    win_nxt      = win_r;
    fill_nxt     = fill_r;
    phase_nxt    = phase_r;
    run_nxt      = run_r;
    held_nxt     = held_r;
    bits_nxt     = bits_r;
    done_cnt_nxt = done_cnt_r;
    grp_nxt      = grp_r;
    gfill_nxt    = gfill_r;
    img_done_nxt = img_done_r;
    end_nxt      = end_r;
    resn_nxt     = resn_r;
    ovalid_nxt   = ovalid_r;
    odata_nxt    = odata_r;
    ocount_nxt   = ocount_r;
    olast_nxt    = olast_r;
    oshort_nxt   = oshort_r;

    // retire the held result once it is taken
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    // Load a byte, clearing the decoder on stream start
    if (cmd.load) begin
      if (in_tuser[0]) begin
        win_nxt      = '0;
        fill_nxt     = '0;
        phase_nxt    = bprle_pkg::PH_CTRL;
        run_nxt      = '0;
        held_nxt     = '0;
        bits_nxt     = '0;
        done_cnt_nxt = '0;
        grp_nxt      = '0;
        gfill_nxt    = '0;
        img_done_nxt = 1'b0;
      end
      if (!stat.skip) begin
        // drop the byte if the window has no room
        if (base_fill <= FW'(8)) begin
          win_nxt  = {base_win[BW-1:0], in_tdata};
          fill_nxt = base_fill + FW'(8);
        end
        end_nxt  = in_tlast;
        resn_nxt = '0;
      end
    end

    // Advance one decode step
    if (cmd.step) begin
      phase_nxt = phase_c;
      run_nxt   = run_c;
      if (do_take) begin
        win_nxt  = take_rem;
        fill_nxt = take_sh;
        bits_nxt = bits_sat;
      end
      if (do_held) begin
        held_nxt = take_v;
      end
      if (do_emit) begin
        done_cnt_nxt = VW'(done_inc);
        if (push_if_emit) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = grp_ins;
          ocount_nxt = gfill_inc;
          olast_nxt  = emit_final;
          oshort_nxt = 1'b0;
          grp_nxt    = '0;
          gfill_nxt  = '0;
          resn_nxt   = resn_r + bprle_pkg::RESN_W'(1);
          if (emit_final) begin
            img_done_nxt = 1'b1;
          end
        end else begin
          grp_nxt   = grp_ins;
          gfill_nxt = gfill_inc;
        end
      end
    end

    // Flush the partial group at stream end
    if (cmd.flush) begin
      ovalid_nxt   = 1'b1;
      odata_nxt    = grp_r;
      ocount_nxt   = gfill_r;
      olast_nxt    = 1'b1;
      oshort_nxt   = done_ext < total;
      grp_nxt      = '0;
      gfill_nxt    = '0;
      img_done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= '0;
      fill_r     <= '0;
      phase_r    <= bprle_pkg::PH_CTRL;
      run_r      <= '0;
      held_r     <= '0;
      bits_r     <= '0;
      done_cnt_r <= '0;
      grp_r      <= '0;
      gfill_r    <= '0;
      img_done_r <= 1'b0;
      end_r      <= 1'b0;
      resn_r     <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      win_r      <= win_nxt;
      fill_r     <= fill_nxt;
      phase_r    <= phase_nxt;
      run_r      <= run_nxt;
      held_r     <= held_nxt;
      bits_r     <= bits_nxt;
      done_cnt_r <= done_cnt_nxt;
      grp_r      <= grp_nxt;
      gfill_r    <= gfill_nxt;
      img_done_r <= img_done_nxt;
      end_r      <= end_nxt;
      resn_r     <= resn_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    odata_r  <= odata_nxt;
    ocount_r <= ocount_nxt;
    olast_r  <= olast_nxt;
    oshort_r <= oshort_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = {oshort_r, ocount_r};
  assign out_tlast  = olast_r;

endmodule

[design/bit_packed_rle_decoder.sv]
// Bit-packed PackBits decoder. Each accepted byte is first loaded into the 16-bit bit
// window; the decoder then runs decode steps (a control field, a repeat value, or one
// emitted value) and a closing step before the next byte is taken. A repeat run emits
// its held value once per step, then takes a further step to return to the next control
// field. The single shared decode step in the datapath sets this order; a stalled result
// register holds it up. Values leave packed up to eight to a transfer.
// Top level: depends on bprle_pkg, bprle_regs, bprle_ctrl and bprle_dpath.
module bit_packed_rle_decoder #(
  parameter int MAX_PIXELS  = bprle_pkg::MAX_PIXELS_DEF,
  parameter int GROUP_LANES = bprle_pkg::GROUP_LANES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bprle_pkg::BYTE_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]                    in_tuser,   // [0] stream_start
  input  logic                          in_tlast,   // stream_end
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bprle_pkg::GROUP_W-1:0] out_tdata,  // [63:0] pixel_group
  output logic [bprle_pkg::OUSER_W-1:0] out_tuser,  // [3:0] group_count, [4] stream_short
  output logic                          out_tlast,  // last_group
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bprle_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [bprle_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [bprle_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);

  bprle_pkg::cfg_t     cfg;
  bprle_pkg::dp_cmd_t  cmd;
  bprle_pkg::dp_stat_t stat;

  bprle_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bprle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bprle_dpath #(
    .MAX_PIXELS  (MAX_PIXELS),
    .GROUP_LANES (GROUP_LANES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[design/bprle_checker.sv]
// Port-level checks of the bit-packed RLE decoder, bound to the top level.
// Depends on bprle_pkg and bit_packed_rle_decoder_macros.svh.
`include "bit_packed_rle_decoder_macros.svh"

module bprle_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [bprle_pkg::BYTE_W-1:0]  in_tdata,
  input logic [0:0]                    in_tuser,
  input logic                          in_tlast,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [bprle_pkg::GROUP_W-1:0] out_tdata,
  input logic [bprle_pkg::OUSER_W-1:0] out_tuser,
  input logic                          out_tlast,
  input logic                          cfg_psel,
  input logic                          cfg_penable,
  input logic                          cfg_pwrite,
  input logic [bprle_pkg::ADDR_W-1:0]  cfg_paddr,
  input logic [bprle_pkg::PDATA_W-1:0] cfg_pwdata,
  input logic [bprle_pkg::PDATA_W-1:0] cfg_prdata,
  input logic                          cfg_pready
);

  // Hold a stalled result
  `BPRLE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")

  // A short stream is only reported on the closing transfer
  `BPRLE_ASSERT_NOW(a_short_last, clk, rst_n, out_tvalid && out_tuser[4], out_tlast, "short flag without last group")

  // A mid-image group is never empty and never over eight lanes
  `BPRLE_ASSERT_NOW(a_mid_count, clk, rst_n, out_tvalid && !out_tlast, (out_tuser[3:0] != 4'd0) && (out_tuser[3:0] <= 4'd8) && !out_tuser[4], "bad mid-image group count")

  // Lanes past the count stay zero, checked on the top lane only
  `BPRLE_ASSERT_NOW(a_top_lane, clk, rst_n, out_tvalid && (out_tuser[3:0] < 4'd8), out_tdata[63:56] == 8'd0, "unused lane not zero")

endmodule

bind bit_packed_rle_decoder bprle_checker u_bprle_checker (.*);

[test/testbench.sv]
// Self-checking bench for bit_packed_rle_decoder: bit-aligned PackBits streams in,
// packed pixel groups out, checked against an in-bench decoder under varied stalls.
// Depends on bprle_pkg and the bit_packed_rle_decoder RTL.
module testbench;

  localparam int MAX_PIX       = 65536;
  localparam int LANES         = 8;
  localparam int REPEAT_BASE   = 257;
  localparam int PUSH_BUDGET   = 17;
  localparam int BITS_SAT      = 20'hFFFFF;
  localparam int RANDOM_ITEMS  = 300;
  localparam int PHASE_ITEMS   = 30;
  localparam int SETTLE_CYCLES = 400;
  localparam int QUIET_LIMIT   = 20000;
  localparam int MAX_REPORTS   = 50;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_first;
    logic       is_last;
  } byte_xfer_t;

  typedef struct packed {
    logic [63:0] pixels;
    logic [3:0]  count;
    logic        last_group;
    logic        cut_short;
  } group_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bit_packed_rle_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] data_byte
    .in_tuser   (in_tuser),   // [0] stream_start
    .in_tlast   (in_tlast),   // stream_end
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [63:0] pixel_group
    .out_tuser  (out_tuser),  // [3:0] group_count, [4] stream_short
    .out_tlast  (out_tlast),  // last_group
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #2 clk = ~clk;

  // Stimulus and expectation stores
  byte_xfer_t pending_bytes[$];
  group_t     expected_groups[$];
  bit         stream_bits[$];
  int         sender_idle_pct = 0;
  int         receiver_stall_pct = 0;
  int         error_count = 0;
  int         queued_items = 0;
  int         quiet_cycles = 0;

  // Register shadow, reset values
  logic [3:0]  cfg_vbits = 4'd8;
  logic [16:0] cfg_total = 17'd65536;
  logic [15:0] cfg_limit = 16'd65535;

  // Decoder state
  logic [15:0]       win_bits = '0;
  int                win_fill = 0;
  bprle_pkg::phase_t dec_phase = bprle_pkg::PH_CTRL;
  int                run_left = 0;
  int                held_val = 0;
  int                bits_used = 0;
  int                pixels_done = 0;
  logic [63:0]       grp_data = '0;
  int                grp_fill = 0;
  bit                image_finished = 1'b0;
  int                step_pushes = 0;

  function automatic int value_width();
    if (cfg_vbits == 0) return 1;
    return (cfg_vbits > 8) ? 8 : int'(cfg_vbits);
  endfunction

  function automatic int image_total();
    return (cfg_total > MAX_PIX) ? MAX_PIX : int'(cfg_total);
  endfunction

  function automatic void clear_decoder();
    win_bits = '0; win_fill = 0; dec_phase = bprle_pkg::PH_CTRL;
    run_left = 0; held_val = 0;
    bits_used = 0; pixels_done = 0; grp_data = '0; grp_fill = 0; image_finished = 1'b0;
  endfunction

  function automatic void push_group(input bit last_group, input bit cut_short);
    expected_groups.push_back('{grp_data, 4'(grp_fill), last_group, cut_short});
    step_pushes++;
    grp_data = '0;
    grp_fill = 0;
  endfunction

  // Hold the pixel back when it would send a group past the per-byte budget
  function automatic bit room_for_pixel();
    bit sends;
    sends = (grp_fill + 1 >= LANES) || (pixels_done + 1 >= image_total());
    return !sends || step_pushes < PUSH_BUDGET;
  endfunction

  function automatic void place_pixel(input int v);
    grp_data = grp_data | (64'(v & 8'hFF) << (8 * grp_fill));
    grp_fill++;
    pixels_done++;
    if (pixels_done >= image_total()) begin
      push_group(1'b1, 1'b0);
      image_finished = 1'b1;
    end else if (grp_fill >= LANES) begin
      push_group(1'b0, 1'b0);
    end
  endfunction

  function automatic int take_bits(input int n);
    int sh;
    int v;
    sh = win_fill - n;
    v = (int'(win_bits) >> sh) & ((1 << n) - 1);
    win_fill = sh;
    win_bits = win_bits & 16'((1 << sh) - 1);
    bits_used = (bits_used + n > BITS_SAT) ? BITS_SAT : bits_used + n;
    return v;
  endfunction

  // Decode as far as the window, the control limit and the budget allow
  function automatic void decode_window();
    int vb;
    int c;
    vb = value_width();
    while (1) begin
      if (image_finished || pixels_done >= image_total()) return;
      case (dec_phase)
        bprle_pkg::PH_REP: begin
          if (run_left == 0) dec_phase = bprle_pkg::PH_CTRL;
          else if (!room_for_pixel()) return;
          else begin
            run_left--;
            place_pixel(held_val);
          end
        end
        bprle_pkg::PH_CTRL: begin
          if (bits_used >= int'(cfg_limit) * 8 || win_fill < 8) return;
          c = take_bits(8);
          if (c > int'(bprle_pkg::CTRL_NOP)) begin
            run_left = REPEAT_BASE - c;
            dec_phase = bprle_pkg::PH_RVAL;
          end else if (c < int'(bprle_pkg::CTRL_NOP)) begin
            run_left = c + 1;
            dec_phase = bprle_pkg::PH_LIT;
          end
        end
        bprle_pkg::PH_RVAL: begin
          if (win_fill < vb) return;
          held_val = take_bits(vb);
          dec_phase = bprle_pkg::PH_REP;
        end
        default: begin
          if (run_left == 0) dec_phase = bprle_pkg::PH_CTRL;
          else if (win_fill < vb || !room_for_pixel()) return;
          else begin
            run_left--;
            place_pixel(take_bits(vb));
            if (run_left == 0) dec_phase = bprle_pkg::PH_CTRL;
          end
        end
      endcase
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] data, input bit first, input bit last);
    step_pushes = 0;
    if (first) clear_decoder();
    if (image_finished) return;
    // Drop the byte if the window has no room for it
    if (win_fill + 8 <= 16) begin
      win_bits = {win_bits[7:0], data};
      win_fill += 8;
    end
    decode_window();
    if (last && !image_finished) begin
      push_group(1'b1, pixels_done < image_total());
      image_finished = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < MAX_REPORTS)
      $display("MISMATCH %s: got %h, want %h", what, got, want);
    error_count++;
  endtask

  // Track register writes
  always @(posedge clk) begin
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[3:2])
        bprle_pkg::REG_VALUE_BITS:  cfg_vbits <= cfg_pwdata[3:0];
        bprle_pkg::REG_PIXEL_TOTAL: cfg_total <= cfg_pwdata[16:0];
        bprle_pkg::REG_BYTE_LIMIT:  cfg_limit <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Predict the groups of each accepted byte
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) predict_byte(in_tdata, in_tuser[0], in_tlast);
  end

  // Driver: offer the next byte once the current transfer is done
  always @(posedge clk) begin : drive_bytes
    byte_xfer_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        nxt = pending_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.data;
        in_tuser  <= nxt.is_first;
        in_tlast  <= nxt.is_last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Monitor: compare each group transfer with the oldest expectation
  always @(posedge clk) begin : check_groups
    group_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_groups.size() == 0) begin
        report_mismatch("unexpected group", out_tdata, '0);
      end else begin
        want = expected_groups.pop_front();
        if (out_tdata !== want.pixels)
          report_mismatch("pixel_group", out_tdata, want.pixels);
        if (out_tuser[3:0] !== want.count)
          report_mismatch("group_count", 64'(out_tuser[3:0]), 64'(want.count));
        if (out_tlast !== want.last_group)
          report_mismatch("last_group", 64'(out_tlast), 64'(want.last_group));
        if (out_tuser[4] !== want.cut_short)
          report_mismatch("stream_short", 64'(out_tuser[4]), 64'(want.cut_short));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bit_packed_rle_decoder verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_config(input int vbits, input int total, input int limit);
    cfg_write(bprle_pkg::REG_VALUE_BITS, 32'(vbits));
    cfg_write(bprle_pkg::REG_PIXEL_TOTAL, 32'(total));
    cfg_write(bprle_pkg::REG_BYTE_LIMIT, 32'(limit));
    @(negedge clk);
  endtask

  task automatic set_idle(input idle_mode_t mode);
    sender_idle_pct    = (mode == IDLE_SENDER) ? 79 : (mode == IDLE_BOTH) ? 21 : 0;
    receiver_stall_pct = (mode == IDLE_RECEIVER) ? 79 : (mode == IDLE_BOTH) ? 21 : 0;
  endtask

  // Wait until every byte is taken and every group has arrived, then let the block settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_tvalid || expected_groups.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_byte(input logic [7:0] data, input bit first, input bit last);
    pending_bytes.push_back('{data, first, last});
    queued_items++;
  endtask

  function automatic void append_bits(input int v, input int n);
    for (int k = n - 1; k >= 0; k--) stream_bits.push_back((v >> k) & 1);
  endfunction

  // Build one compressed stream of random packets, sometimes broken, and queue its bytes
  task automatic queue_stream(input int vb, input int packets);
    int kind;
    int cnt;
    int nbytes;
    int variant;
    int idx;
    logic [7:0] b;
    stream_bits.delete();
    for (int p = 0; p < packets; p++) begin
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
        append_bits(int'(bprle_pkg::CTRL_NOP), 8);
      end else if (kind < 7) begin
        case ($urandom_range(0, 7))
          0: cnt = 128;
          1: cnt = $urandom_range(2, 128);
          default: cnt = $urandom_range(2, 20);
        endcase
        append_bits(REPEAT_BASE - cnt, 8);
        append_bits($urandom_range(0, (1 << vb) - 1), vb);
      end else if (kind < 15) begin
        if (vb == 1 && $urandom_range(0, 7) == 0) cnt = 128;
        else cnt = $urandom_range(1, (vb <= 2) ? 24 : 8);
        append_bits(cnt - 1, 8);
        for (int k = 0; k < cnt; k++) append_bits($urandom_range(0, (1 << vb) - 1), vb);
      end else begin
        append_bits($urandom_range(0, 255), 8);
      end
    end
    nbytes = (stream_bits.size() + 7) / 8;
    variant = $urandom_range(0, 9);
    if (variant == 2) nbytes = $urandom_range(1, nbytes);
    for (int i = 0; i < nbytes; i++) begin
      b = '0;
      for (int k = 0; k < 8; k++) begin
        idx = i * 8 + k;
        b = {b[6:0], (idx < stream_bits.size()) ? stream_bits[idx] : 1'($urandom_range(0, 1))};
      end
      queue_byte(b, (i == 0) && variant != 0, (i == nbytes - 1) && variant != 1);
    end
  endtask

  initial begin : stimulus
    int phase;
    int phase_start;
    int vb_eff;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_idle(IDLE_NONE);

    // Reset settings: no-op control, one literal, short repeat, longest repeat, early end
    queue_byte(8'h80, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'h81, 1'b0, 1'b0);
    queue_byte(8'hAA, 1'b0, 1'b1);
    wait_drained();

    // One-bit values, longest literal; the image completes and the remaining bytes are dropped
    set_config(1, 20, 65535);
    queue_byte(8'h7F, 1'b1, 1'b0);
    for (int i = 0; i < 16; i++) queue_byte((i % 2) ? 8'h00 : 8'hFF, 1'b0, i == 15);
    wait_drained();

    // Random streams: extreme settings first, then random ones
    queued_items = 0;
    phase = 0;
    while (queued_items < RANDOM_ITEMS) begin
      case (phase)
        0: set_config(15, 131071, 0);
        1: set_config(0, 0, 65535);
        2: set_config(1, 1, 1);
        3: set_config(8, 65536, 65535);
        default: set_config($urandom_range(1, 8),
                            ($urandom_range(0, 7) == 0) ? $urandom_range(65537, 131071)
                                                        : $urandom_range(1, 160),
                            $urandom_range(2, 48));
      endcase
      set_idle(idle_mode_t'(phase % 4));
      vb_eff = value_width();
      phase_start = queued_items;
      while (queued_items - phase_start < PHASE_ITEMS)
        queue_stream(vb_eff, $urandom_range(1, 6));
      wait_drained();
      phase++;
    end

    if (error_count == 0) begin
      $display("bit_packed_rle_decoder verification clean");
    end else begin
      $display("bit_packed_rle_decoder verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/bprle_pkg.sv
design/bprle_regs.sv
design/bprle_ctrl.sv
design/bprle_dpath.sv
design/bit_packed_rle_decoder.sv
design/bprle_checker.sv
test/testbench.sv
